FILE: rtl/rstp_pkg.sv
// Package for the range scan text parser: byte classes, queue item, token and status codes.
`timescale 1ns / 1ps
`default_nettype none
package rstp_pkg;

	// Byte codes the parser cares about
	localparam logic [7:0] CHAR_LF    = 8'd10;
	localparam logic [7:0] CHAR_TAB   = 8'd9;
	localparam logic [7:0] CHAR_VT    = 8'd11;
	localparam logic [7:0] CHAR_FF    = 8'd12;
	localparam logic [7:0] CHAR_CR    = 8'd13;
	localparam logic [7:0] CHAR_SPACE = 8'd32;
	localparam logic [7:0] CHAR_COMMA = 8'd44;
	localparam logic [7:0] CHAR_PLUS  = 8'd43;
	localparam logic [7:0] CHAR_MINUS = 8'd45;
	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_NINE  = 8'd57;
	localparam logic [7:0] CHAR_UC_A  = 8'd65;
	localparam logic [7:0] CHAR_UC_C  = 8'd67;
	localparam logic [7:0] CHAR_UC_I  = 8'd73;
	localparam logic [7:0] CHAR_UC_R  = 8'd82;
	localparam logic [7:0] CHAR_UC_S  = 8'd83;

	// Depth of the queue between classifier and parser
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [3:0] {
		CH_NEWLINE,
		CH_SPACE,
		CH_COMMA,
		CH_DIGIT,
		CH_PLUS,
		CH_MINUS,
		CH_A,
		CH_S,
		CH_I,
		CH_C,
		CH_R,
		CH_OTHER
	} char_class_t;

	// One classified byte as it travels through the queue
	typedef struct packed {
		char_class_t cls;
		logic [3:0]  digit;
	} item_t;

	typedef enum logic [2:0] {
		TOK_EMPTY,
		TOK_A,
		TOK_S,
		TOK_I,
		TOK_C,
		TOK_CR,
		TOK_CRC,
		TOK_NONE
	} tok_t;

	typedef enum logic [1:0] {
		NP_LEAD,
		NP_DIGITS,
		NP_DONE
	} num_phase_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_LOW_SIGNAL  = 3'd1,
		ST_INVALID     = 3'd2,
		ST_CRC         = 3'd3,
		ST_MISSING     = 3'd4,
		ST_ANGLE_RANGE = 3'd5
	} status_t;

endpackage
`default_nettype wire

FILE: rtl/rstp_front.sv
// Front end: classifies each received byte and hands it to the queue.
`timescale 1ns / 1ps
`default_nettype none
module rstp_front (
	input  wire logic          char_valid,
	input  wire logic [7:0]    char_in,
	output logic               char_stall,
	input  wire logic          queue_full,
	output logic               push_valid,
	output rstp_pkg::item_t    push_item
);

	assign char_stall = queue_full;
	assign push_valid = char_valid & ~queue_full;

	always_comb begin
		push_item.digit = char_in[3:0];
		unique case (char_in) inside
			rstp_pkg::CHAR_LF: push_item.cls = rstp_pkg::CH_NEWLINE;
			rstp_pkg::CHAR_TAB, rstp_pkg::CHAR_VT, rstp_pkg::CHAR_FF,
			rstp_pkg::CHAR_CR, rstp_pkg::CHAR_SPACE: push_item.cls = rstp_pkg::CH_SPACE;
			rstp_pkg::CHAR_COMMA: push_item.cls = rstp_pkg::CH_COMMA;
			[rstp_pkg::CHAR_ZERO:rstp_pkg::CHAR_NINE]: push_item.cls = rstp_pkg::CH_DIGIT;
			rstp_pkg::CHAR_PLUS:  push_item.cls = rstp_pkg::CH_PLUS;
			rstp_pkg::CHAR_MINUS: push_item.cls = rstp_pkg::CH_MINUS;
			rstp_pkg::CHAR_UC_A:  push_item.cls = rstp_pkg::CH_A;
			rstp_pkg::CHAR_UC_S:  push_item.cls = rstp_pkg::CH_S;
			rstp_pkg::CHAR_UC_I:  push_item.cls = rstp_pkg::CH_I;
			rstp_pkg::CHAR_UC_C:  push_item.cls = rstp_pkg::CH_C;
			rstp_pkg::CHAR_UC_R:  push_item.cls = rstp_pkg::CH_R;
			default:              push_item.cls = rstp_pkg::CH_OTHER;
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/rstp_queue.sv
// Short FIFO of classified bytes between the front end and the parser.
`timescale 1ns / 1ps
`default_nettype none
module rstp_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	input  wire rstp_pkg::item_t push_item,
	output logic                 full,
	output logic                 head_valid,
	output rstp_pkg::item_t      head_item,
	input  wire logic            pop
);

	localparam int Depth  = rstp_pkg::QUEUE_DEPTH;
	localparam int PtrW   = $clog2(Depth);
	localparam int CountW = $clog2(Depth + 1);

	rstp_pkg::item_t    entries_q [Depth];
	logic [PtrW-1:0]    wr_ptr_q;
	logic [PtrW-1:0]    rd_ptr_q;
	logic [CountW-1:0]  count_q;
	logic               do_pop;

	assign full       = (count_q == CountW'(Depth));
	assign head_valid = (count_q != '0);
	assign head_item  = entries_q[rd_ptr_q];
	assign do_pop     = pop & head_valid;

	always_ff @(posedge clk) begin
		if (push_valid) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_valid) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push_valid, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: rtl/rstp_back.sv
// Back end: line parser state, result assembly and the output register.
`timescale 1ns / 1ps
`default_nettype none
module rstp_back #(
	parameter int LAST_ANGLE = 359
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            head_valid,
	input  wire rstp_pkg::item_t head_item,
	output logic                 pop,
	output logic                 meas_valid,
	input  wire logic            meas_stall,
	output logic [8:0]           angle_deg,
	output logic [2:0]           status_code,
	output logic [15:0]          distance_mm,
	output logic [15:0]          strength,
	output logic                 scan_done,
	output logic [31:0]          scan_index
);

	localparam logic [9:0] LastAngle = 10'(LAST_ANGLE);
	localparam logic [9:0] AngleMax  = 10'd1023;
	localparam logic [15:0] ValMax   = 16'hFFFF;

	typedef struct packed {
		logic [2:0]           field_idx;
		rstp_pkg::tok_t       tok;
		logic                 rejected;
		logic                 seen;
		logic                 neg;
		logic                 pending;
		rstp_pkg::num_phase_t phase;
		rstp_pkg::tok_t       status_tok;
		logic [9:0]           angle;
		logic [15:0]          dist_mm;
		logic [15:0]          str;
	} parse_t;

	localparam parse_t ParseClear = '{
		field_idx: 3'd0, tok: rstp_pkg::TOK_EMPTY, rejected: 1'b0, seen: 1'b0,
		neg: 1'b0, pending: 1'b0, phase: rstp_pkg::NP_LEAD,
		status_tok: rstp_pkg::TOK_EMPTY, angle: 10'd0, dist_mm: 16'd0, str: 16'd0
	};

	function automatic logic [9:0] sat_angle(input logic [9:0] acc, input logic [3:0] d);
		logic [13:0] v;
		v = {4'd0, acc} * 14'd10 + {10'd0, d};
		return (v > {4'd0, AngleMax}) ? AngleMax : v[9:0];
	endfunction

	function automatic logic [15:0] sat_val(input logic [15:0] acc, input logic [3:0] d);
		logic [19:0] v;
		v = {4'd0, acc} * 20'd10 + {16'd0, d};
		return (v > {4'd0, ValMax}) ? ValMax : v[15:0];
	endfunction

	function automatic rstp_pkg::tok_t tok_next(input rstp_pkg::tok_t t,
			input rstp_pkg::char_class_t c);
		rstp_pkg::tok_t n;
		n = rstp_pkg::TOK_NONE;
		case (t)
			rstp_pkg::TOK_EMPTY: begin
				case (c)
					rstp_pkg::CH_A: n = rstp_pkg::TOK_A;
					rstp_pkg::CH_S: n = rstp_pkg::TOK_S;
					rstp_pkg::CH_I: n = rstp_pkg::TOK_I;
					rstp_pkg::CH_C: n = rstp_pkg::TOK_C;
					default:        n = rstp_pkg::TOK_NONE;
				endcase
			end
			rstp_pkg::TOK_C:  n = (c == rstp_pkg::CH_R) ? rstp_pkg::TOK_CR : rstp_pkg::TOK_NONE;
			rstp_pkg::TOK_CR: n = (c == rstp_pkg::CH_C) ? rstp_pkg::TOK_CRC : rstp_pkg::TOK_NONE;
			default:          n = rstp_pkg::TOK_NONE;
		endcase
		return n;
	endfunction

	// a held whitespace byte joins the field as content
	function automatic parse_t feed_space(input parse_t s);
		parse_t r;
		r = s;
		r.tok = rstp_pkg::TOK_NONE;
		if (s.phase == rstp_pkg::NP_DIGITS) begin
			r.phase = rstp_pkg::NP_DONE;
		end
		r.seen    = 1'b1;
		r.pending = 1'b0;
		return r;
	endfunction

	function automatic parse_t feed_char(input parse_t s, input rstp_pkg::item_t it);
		parse_t r;
		r = s;
		r.tok = tok_next(s.tok, it.cls);
		if (s.phase != rstp_pkg::NP_DONE) begin
			case (it.cls)
				rstp_pkg::CH_DIGIT: begin
					r.phase = rstp_pkg::NP_DIGITS;
					case (s.field_idx)
						3'd1:    r.angle   = sat_angle(s.angle, it.digit);
						3'd2:    r.dist_mm = sat_val(s.dist_mm, it.digit);
						3'd3:    r.str     = sat_val(s.str, it.digit);
						default: r.angle   = s.angle;
					endcase
				end
				rstp_pkg::CH_PLUS, rstp_pkg::CH_MINUS: begin
					if (s.phase == rstp_pkg::NP_LEAD) begin
						r.neg   = (it.cls == rstp_pkg::CH_MINUS);
						r.phase = rstp_pkg::NP_DIGITS;
					end else begin
						r.phase = rstp_pkg::NP_DONE;
					end
				end
				default: r.phase = rstp_pkg::NP_DONE;
			endcase
		end
		r.seen = 1'b1;
		return r;
	endfunction

	function automatic parse_t finish_field(input parse_t s);
		parse_t r;
		r = s;
		case (s.field_idx)
			3'd0: r.rejected = (s.tok != rstp_pkg::TOK_A);
			3'd1: if (s.neg) r.angle = '0;
			3'd2: begin
				r.status_tok = s.tok;
				if (s.neg) r.dist_mm = '0;
			end
			3'd3: if (s.neg) r.str = '0;
			default: r.rejected = s.rejected;
		endcase
		r.tok   = rstp_pkg::TOK_EMPTY;
		r.neg   = 1'b0;
		r.phase = rstp_pkg::NP_LEAD;
		return r;
	endfunction

	parse_t            st_q;
	parse_t            st_d;
	parse_t            work_st;
	parse_t            fin_st;
	logic [31:0]       scan_cnt_q;
	logic [2:0]        present;
	rstp_pkg::status_t status;
	logic              status_kept;
	logic              emit;
	logic              done;
	logic              out_free;
	logic              is_newline;
	logic              out_valid_q;

	assign is_newline = (head_item.cls == rstp_pkg::CH_NEWLINE);
	assign out_free   = ~out_valid_q | ~meas_stall;
	assign pop        = head_valid & (~is_newline | out_free);
	assign meas_valid = out_valid_q;

	// Line end view of the state
	assign fin_st  = st_q.seen ? finish_field(st_q) : st_q;
	assign present = st_q.field_idx + {2'd0, st_q.seen};
	assign emit    = (present != 3'd0) & ~fin_st.rejected;

	always_comb begin
		if (present < 3'd3) begin
			status = rstp_pkg::ST_MISSING;
		end else if (fin_st.status_tok == rstp_pkg::TOK_S) begin
			status = rstp_pkg::ST_LOW_SIGNAL;
		end else if (fin_st.status_tok == rstp_pkg::TOK_I) begin
			status = rstp_pkg::ST_INVALID;
		end else if (fin_st.status_tok == rstp_pkg::TOK_CRC) begin
			status = rstp_pkg::ST_CRC;
		end else begin
			status = (present < 3'd4) ? rstp_pkg::ST_MISSING : rstp_pkg::ST_OK;
		end
		if (status != rstp_pkg::ST_MISSING && fin_st.angle > LastAngle) begin
			status = rstp_pkg::ST_ANGLE_RANGE;
		end
	end

	assign status_kept = (status != rstp_pkg::ST_MISSING) &&
		(status != rstp_pkg::ST_ANGLE_RANGE);
	assign done = status_kept & (fin_st.angle == LastAngle);

	always_comb begin
		work_st = st_q;
		if (st_q.pending) begin
			work_st = feed_space(st_q);
		end
		if (head_item.cls == rstp_pkg::CH_COMMA) begin
			work_st = finish_field(work_st);
			if (work_st.field_idx < 3'd4) begin
				work_st.field_idx = work_st.field_idx + 1'b1;
			end
			work_st.seen = 1'b0;
		end else begin
			work_st = feed_char(work_st, head_item);
		end
	end

	always_comb begin
		st_d = st_q;
		if (pop) begin
			case (head_item.cls)
				rstp_pkg::CH_NEWLINE: st_d = ParseClear;
				rstp_pkg::CH_SPACE: begin
					if (st_q.field_idx != 3'd0 || st_q.seen) begin
						st_d.pending = 1'b1;
					end
				end
				default: st_d = work_st;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ParseClear;
			scan_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (pop && is_newline && emit) begin
				out_valid_q <= 1'b1;
				if (done) begin
					scan_cnt_q <= scan_cnt_q + 1'b1;
				end
			end else if (!meas_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && is_newline && emit) begin
			angle_deg   <= status_kept ? fin_st.angle[8:0] : 9'd0;
			status_code <= status;
			distance_mm <= (status == rstp_pkg::ST_OK) ? fin_st.dist_mm : 16'd0;
			strength    <= (status == rstp_pkg::ST_OK) ? fin_st.str : 16'd0;
			scan_done   <= done;
			scan_index  <= done ? scan_cnt_q : 32'd0;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/range_scan_text_parser.sv
// Top level of the range scan text parser: classifier, byte queue and line parser.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   The char channel takes one received byte per item (char_valid/char_stall).
//   Lines look like "A,<angle>,<distance>,<strength>" or "A,<angle>,S|I|CRC",
//   ended by byte 10, with whitespace trimmed at both ends of the line.
//   The meas channel gives one item per accepted line (meas_valid/meas_stall):
//   angle, status code, distance, strength, scan completion flag and scan index.
//   Lines whose first field is not exactly "A", and blank lines, give no item.
// Throughput: one byte per cycle while char_stall is low. Every byte, newline included,
//   is taken in a single parser step.
// Path: an accepted newline is written into the byte queue, then popped
//   through the parser into the output register, which raises meas_valid.
// Stall: the output register holds its item while meas_stall is high; bytes
//   keep flowing until a newline meets a full output register. The 4-entry
//   queue then fills and char_stall rises when it is full.
// Reset: arst_n clears the parser state, the queue, the output valid and the
//   scan counter; no item is pending after reset.
module range_scan_text_parser #(
	parameter int LAST_ANGLE = 359
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        char_valid,
	output logic             char_stall,
	input  wire logic [7:0]  char_in,
	output logic             meas_valid,
	input  wire logic        meas_stall,
	output logic [8:0]       angle_deg,
	output logic [2:0]       status_code,
	output logic [15:0]      distance_mm,
	output logic [15:0]      strength,
	output logic             scan_done,
	output logic [31:0]      scan_index
);

	logic            push_valid;
	rstp_pkg::item_t push_item;
	logic            queue_full;
	logic            head_valid;
	rstp_pkg::item_t head_item;
	logic            pop;

	// byte classification, no state
	rstp_front u_front (
		.char_valid (char_valid),
		.char_in    (char_in),
		.char_stall (char_stall),
		.queue_full (queue_full),
		.push_valid (push_valid),
		.push_item  (push_item)
	);

	// decouples the input side from output stalls
	rstp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop)
	);

	// field parser and result register
	rstp_back #(
		.LAST_ANGLE (LAST_ANGLE)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_item   (head_item),
		.pop         (pop),
		.meas_valid  (meas_valid),
		.meas_stall  (meas_stall),
		.angle_deg   (angle_deg),
		.status_code (status_code),
		.distance_mm (distance_mm),
		.strength    (strength),
		.scan_done   (scan_done),
		.scan_index  (scan_index)
	);

endmodule
`default_nettype wire

FILE: rtl/rstp_checker.sv
// Port-level checker for the range scan text parser, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module rstp_checker #(
	parameter int LAST_ANGLE = 359
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        meas_valid,
	input wire logic        meas_stall,
	input wire logic [8:0]  angle_deg,
	input wire logic [2:0]  status_code,
	input wire logic [15:0] distance_mm,
	input wire logic [15:0] strength,
	input wire logic        scan_done,
	input wire logic [31:0] scan_index
);

	localparam logic [9:0] LastAngle = 10'(LAST_ANGLE);

	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		meas_valid && meas_stall |=> meas_valid)
		else $error("meas_valid dropped while stalled");

	a_error_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		meas_valid && status_code != rstp_pkg::ST_OK |-> distance_mm == 16'd0 && strength == 16'd0)
		else $error("distance or strength set on a non-ok status");

	a_error_no_angle: assert property (@(posedge clk) disable iff (!arst_n)
		meas_valid && (status_code == rstp_pkg::ST_MISSING ||
			status_code == rstp_pkg::ST_ANGLE_RANGE) |-> angle_deg == 9'd0 && !scan_done)
		else $error("angle or scan_done set on an error status");

	a_done_angle: assert property (@(posedge clk) disable iff (!arst_n)
		meas_valid && scan_done |-> angle_deg == LastAngle[8:0])
		else $error("scan_done away from the last angle");

	a_number_zero: assert property (@(posedge clk) disable iff (!arst_n)
		meas_valid && !scan_done |-> scan_index == 32'd0)
		else $error("scan_index set without scan_done");

endmodule

bind range_scan_text_parser rstp_checker #(
	.LAST_ANGLE (LAST_ANGLE)
) u_rstp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.meas_valid  (meas_valid),
	.meas_stall  (meas_stall),
	.angle_deg   (angle_deg),
	.status_code (status_code),
	.distance_mm (distance_mm),
	.strength    (strength),
	.scan_done   (scan_done),
	.scan_index  (scan_index)
);
`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the range scan text parser: directed lines, then random lines.
`timescale 1ns / 1ps
module tb_top;

	localparam int LAST_ANGLE   = 359;
	localparam int TOTAL_BYTES  = 1450;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int DIR_ROWS     = 25;

	// One measurement as the meas channel carries it
	typedef struct packed {
		logic [8:0]        angle;
		rstp_pkg::status_t status;
		logic [15:0]       dist_mm;
		logic [15:0]       str;
		logic              done;
		logic [31:0]       num;
	} meas_t;

	// Directed row: expected item typed in only where it is obvious
	typedef struct packed {
		logic  typed;
		meas_t m;
	} dir_ref_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        char_valid = 1'b0;
	logic        char_stall;
	logic [7:0]  char_in = 8'd0;
	logic        meas_valid;
	logic        meas_stall = 1'b0;
	logic [8:0]  angle_deg;
	logic [2:0]  status_code;
	logic [15:0] distance_mm;
	logic [15:0] strength;
	logic        scan_done;
	logic [31:0] scan_index;

	range_scan_text_parser #(
		.LAST_ANGLE(LAST_ANGLE)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_in(char_in),
		.meas_valid(meas_valid),
		.meas_stall(meas_stall),
		.angle_deg(angle_deg),
		.status_code(status_code),
		.distance_mm(distance_mm),
		.strength(strength),
		.scan_done(scan_done),
		.scan_index(scan_index)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Line parser model: mirrors the block's per-byte state
	// ------------------------------------------------------------------
	int                   fld_idx;     // field number, saturates at 4
	rstp_pkg::tok_t       tok;         // token match of the current field
	rstp_pkg::tok_t       status_tok;  // token seen in field 2
	rstp_pkg::num_phase_t nphase;      // atoi-style reader phase
	logic                 rejected;
	logic                 field_open;  // current field holds a byte of the trimmed line
	logic                 neg;
	logic                 ws_pending;  // whitespace not yet known to be interior
	int                   ang_acc;
	int                   dist_acc;
	int                   str_acc;
	logic [31:0]          scans;

	meas_t pending_meas[$];
	logic  use_typed = 1'b0;
	meas_t typed_meas;

	int bad_count;
	int bytes_sent;
	int lines_sent;
	int meas_checked;
	int scans_seen;
	int cycle_count;
	int send_pct;
	int stall_pct;
	int stall_left;

	logic [7:0] line_buf[$];

	localparam logic [7:0] WS_SET [5] = '{rstp_pkg::CHAR_TAB, rstp_pkg::CHAR_VT,
		rstp_pkg::CHAR_FF, rstp_pkg::CHAR_CR, rstp_pkg::CHAR_SPACE};
	string good_tokens [3] = '{"S", "I", "CRC"};
	string bad_tokens  [4] = '{"CR", "SS", "crc", "C"};
	string bad_heads   [4] = '{"B", "a", "AS", "A "};

	function automatic logic is_blank(logic [7:0] c);
		return c == rstp_pkg::CHAR_TAB || c == rstp_pkg::CHAR_VT || c == rstp_pkg::CHAR_FF
			|| c == rstp_pkg::CHAR_CR || c == rstp_pkg::CHAR_SPACE;
	endfunction

	function automatic int sat_digit(int acc, int d, int cap);
		int v;
		v = acc * 10 + d;
		return (v > cap) ? cap : v;
	endfunction

	function automatic void clear_field();
		tok = rstp_pkg::TOK_EMPTY;
		neg = 1'b0;
		nphase = rstp_pkg::NP_LEAD;
	endfunction

	function automatic void clear_line();
		fld_idx = 0;
		rejected = 1'b0;
		field_open = 1'b0;
		ang_acc = 0;
		dist_acc = 0;
		str_acc = 0;
		ws_pending = 1'b0;
		status_tok = rstp_pkg::TOK_EMPTY;
		clear_field();
	endfunction

	// One byte of field content; whitespace inside a field counts here
	function automatic void feed_char(logic [7:0] c);
		int d;
		if (tok == rstp_pkg::TOK_EMPTY) begin
			if (c == rstp_pkg::CHAR_UC_A)
				tok = rstp_pkg::TOK_A;
			else if (c == rstp_pkg::CHAR_UC_S)
				tok = rstp_pkg::TOK_S;
			else if (c == rstp_pkg::CHAR_UC_I)
				tok = rstp_pkg::TOK_I;
			else if (c == rstp_pkg::CHAR_UC_C)
				tok = rstp_pkg::TOK_C;
			else
				tok = rstp_pkg::TOK_NONE;
		end else if (tok == rstp_pkg::TOK_C) begin
			tok = (c == rstp_pkg::CHAR_UC_R) ? rstp_pkg::TOK_CR : rstp_pkg::TOK_NONE;
		end else if (tok == rstp_pkg::TOK_CR) begin
			tok = (c == rstp_pkg::CHAR_UC_C) ? rstp_pkg::TOK_CRC : rstp_pkg::TOK_NONE;
		end else begin
			tok = rstp_pkg::TOK_NONE;
		end

		if (nphase == rstp_pkg::NP_DONE)
			return;
		if (c >= rstp_pkg::CHAR_ZERO && c <= rstp_pkg::CHAR_NINE) begin
			d = c - rstp_pkg::CHAR_ZERO;
			nphase = rstp_pkg::NP_DIGITS;
			case (fld_idx)
				1: ang_acc = sat_digit(ang_acc, d, 1023);
				2: dist_acc = sat_digit(dist_acc, d, 65535);
				3: str_acc = sat_digit(str_acc, d, 65535);
				default: ;
			endcase
		end else if (nphase == rstp_pkg::NP_LEAD && is_blank(c)) begin
			// leading whitespace of a number is skipped
		end else if (nphase == rstp_pkg::NP_LEAD
				&& (c == rstp_pkg::CHAR_PLUS || c == rstp_pkg::CHAR_MINUS)) begin
			neg = (c == rstp_pkg::CHAR_MINUS);
			nphase = rstp_pkg::NP_DIGITS;
		end else begin
			nphase = rstp_pkg::NP_DONE;
		end
	endfunction

	function automatic void close_field();
		case (fld_idx)
			0: rejected = (tok != rstp_pkg::TOK_A);
			1: if (neg) ang_acc = 0;
			2: begin
				status_tok = tok;
				if (neg) dist_acc = 0;
			end
			3: if (neg) str_acc = 0;
			default: ;
		endcase
		clear_field();
	endfunction

	// Advances the model by one accepted byte; returns 1 with the item a newline causes
	function automatic logic parse_byte(input logic [7:0] c, output meas_t m);
		int                present;
		rstp_pkg::status_t st;
		m = '0;
		if (c == rstp_pkg::CHAR_LF) begin
			if (field_open)
				close_field();
			present = fld_idx + (field_open ? 1 : 0);
			if (present == 0 || rejected) begin
				clear_line();
				return 1'b0;
			end
			if (present < 3)
				st = rstp_pkg::ST_MISSING;
			else if (status_tok == rstp_pkg::TOK_S)
				st = rstp_pkg::ST_LOW_SIGNAL;
			else if (status_tok == rstp_pkg::TOK_I)
				st = rstp_pkg::ST_INVALID;
			else if (status_tok == rstp_pkg::TOK_CRC)
				st = rstp_pkg::ST_CRC;
			else
				st = (present < 4) ? rstp_pkg::ST_MISSING : rstp_pkg::ST_OK;
			// missing field wins over a bad angle
			if (st != rstp_pkg::ST_MISSING && ang_acc > LAST_ANGLE)
				st = rstp_pkg::ST_ANGLE_RANGE;
			m.status = st;
			if (st <= rstp_pkg::ST_CRC) begin
				m.angle = 9'(ang_acc);
				if (st == rstp_pkg::ST_OK) begin
					m.dist_mm = 16'(dist_acc);
					m.str = 16'(str_acc);
				end
				if (ang_acc == LAST_ANGLE) begin
					m.done = 1'b1;
					m.num = scans;
					scans = scans + 32'd1;
				end
			end
			clear_line();
			return 1'b1;
		end
		// whitespace only matters if something non-blank follows on the line
		if (is_blank(c)) begin
			if (fld_idx != 0 || field_open)
				ws_pending = 1'b1;
			return 1'b0;
		end
		if (ws_pending) begin
			ws_pending = 1'b0;
			feed_char(rstp_pkg::CHAR_SPACE);
			field_open = 1'b1;
		end
		if (c == rstp_pkg::CHAR_COMMA) begin
			close_field();
			if (fld_idx < 4)
				fld_idx++;
			field_open = 1'b0;
			return 1'b0;
		end
		feed_char(c);
		field_open = 1'b1;
		return 1'b0;
	endfunction

	// ------------------------------------------------------------------
	// Directed lines; the newline is appended by the driver
	// ------------------------------------------------------------------
	string dir_text [DIR_ROWS] = '{
		"A,0,0,0",
		"A,359,65535,65535",
		"A,1023,1,1",
		"A,99999,S",
		"A,10,S",
		"A,20,I",
		"A,30,CRC",
		"A,5",
		"A",
		"A,360,S",
		"A,359,CRC",
		"",
		"\011 \015 ",
		"B,1,2,3",
		"AA,1,2,3",
		" A, -5 , 70000 ,+12 \015",
		"A,7,S ,1",
		"A,8,CR",
		"A,,,",
		"A,359,1,2,9,9",
		"A,-0,+65536,-1",
		"A,12a3,4x,5",
		"A, ,3,4",
		"A,1,,",
		"A ,1,2,3"
	};

	dir_ref_t dir_ref [DIR_ROWS] = '{
		'{1'b1, '{9'd0,   rstp_pkg::ST_OK,          16'd0,     16'd0,     1'b0, 32'd0}},
		'{1'b1, '{9'd359, rstp_pkg::ST_OK,          16'd65535, 16'd65535, 1'b1, 32'd0}},
		'{1'b1, '{9'd0,   rstp_pkg::ST_ANGLE_RANGE, 16'd0,     16'd0,     1'b0, 32'd0}},
		'{1'b1, '{9'd0,   rstp_pkg::ST_ANGLE_RANGE, 16'd0,     16'd0,     1'b0, 32'd0}},
		'{1'b1, '{9'd10,  rstp_pkg::ST_LOW_SIGNAL,  16'd0,     16'd0,     1'b0, 32'd0}},
		'{1'b1, '{9'd20,  rstp_pkg::ST_INVALID,     16'd0,     16'd0,     1'b0, 32'd0}},
		'{1'b1, '{9'd30,  rstp_pkg::ST_CRC,         16'd0,     16'd0,     1'b0, 32'd0}},
		'{1'b1, '{9'd0,   rstp_pkg::ST_MISSING,     16'd0,     16'd0,     1'b0, 32'd0}},
		'{1'b1, '{9'd0,   rstp_pkg::ST_MISSING,     16'd0,     16'd0,     1'b0, 32'd0}},
		'{1'b1, '{9'd0,   rstp_pkg::ST_ANGLE_RANGE, 16'd0,     16'd0,     1'b0, 32'd0}},
		'{1'b1, '{9'd359, rstp_pkg::ST_CRC,         16'd0,     16'd0,     1'b1, 32'd1}},
		'{1'b0, '0},
		'{1'b0, '0},
		'{1'b0, '0},
		'{1'b0, '0},
		'{1'b0, '0},
		'{1'b0, '0},
		'{1'b0, '0},
		'{1'b0, '0},
		'{1'b0, '0},
		'{1'b0, '0},
		'{1'b0, '0},
		'{1'b0, '0},
		'{1'b0, '0},
		'{1'b0, '0}
	};

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic void note_fail(string msg);
		bad_count++;
		if (bad_count <= 10)
			$display("[%0t] %s", $time, msg);
	endfunction

	// ------------------------------------------------------------------
	// Line builders for the random part
	// ------------------------------------------------------------------
	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			line_buf.insert(line_buf.size(), s[i]);
	endtask

	task automatic add_pad();
		if ($urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 2))
				line_buf.insert(line_buf.size(), WS_SET[$urandom_range(0, 4)]);
	endtask

	task automatic add_number(int v, logic minus);
		if (minus)
			add_text("-");
		else if ($urandom_range(0, 19) == 0)
			add_text("+");
		if ($urandom_range(0, 19) == 0)
			add_text("0");
		add_text($sformatf("%0d", v));
	endtask

	task automatic add_angle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			add_number(LAST_ANGLE, 1'b0);
		else if (r < 80)
			add_number($urandom_range(0, LAST_ANGLE), 1'b0);
		else if (r < 90)
			add_number($urandom_range(LAST_ANGLE + 1, 1023), 1'b0);
		else if (r < 95)
			add_number($urandom_range(1024, 999999), 1'b0);
		else
			add_number($urandom_range(0, 500), 1'b1);
	endtask

	task automatic add_reading();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return;   // empty field reads as 0
		if (r < 70)
			add_number($urandom_range(0, 9999), 1'b0);
		else if (r < 85)
			add_number($urandom_range(0, 65535), 1'b0);
		else if (r < 95)
			add_number($urandom_range(65536, 999999), 1'b0);
		else
			add_number($urandom_range(0, 9999), 1'b1);
	endtask

	task automatic build_line();
		int kind;
		int cut;
		line_buf.delete();
		kind = $urandom_range(0, 99);
		// pure noise: any byte value, newline included
		if (kind >= 85) begin
			repeat ($urandom_range(1, 12))
				line_buf.insert(line_buf.size(), 8'($urandom_range(0, 255)));
			return;
		end
		add_pad();
		if (kind >= 75 && $urandom_range(0, 1) == 1)
			add_text(bad_heads[$urandom_range(0, 3)]);
		else
			add_text("A");
		add_text(",");
		add_pad();
		add_angle();
		add_pad();
		add_text(",");
		if ($urandom_range(0, 9) < 6) begin
			add_pad();
			add_reading();
			add_pad();
			add_text(",");
			add_pad();
			add_reading();
		end else if (kind >= 75) begin
			add_text(bad_tokens[$urandom_range(0, 3)]);
		end else begin
			add_text(good_tokens[$urandom_range(0, 2)]);
		end
		if ($urandom_range(0, 9) == 0)
			add_text(",7,x");
		add_pad();
		// truncated line: fields go missing
		if (kind >= 70 && kind < 75) begin
			cut = $urandom_range(0, line_buf.size());
			while (line_buf.size() > cut)
				void'(line_buf.pop_back());
		end
	endtask

	// ------------------------------------------------------------------
	// char channel driver
	// ------------------------------------------------------------------
	task automatic push_char(logic [7:0] b);
		meas_t m;
		int    gap;
		if ($urandom_range(0, 99) < send_pct) begin
			gap = pick_gap();
			char_valid <= 1'b0;
			char_in <= 8'($urandom_range(0, 255));
			repeat (gap) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_in <= b;
		do
			@(posedge clk);
		while (char_stall);
		bytes_sent++;
		if (parse_byte(b, m))
			pending_meas.insert(pending_meas.size(), use_typed ? typed_meas : m);
	endtask

	task automatic send_line();
		foreach (line_buf[i])
			push_char(line_buf[i]);
		push_char(rstp_pkg::CHAR_LF);
		lines_sent++;
	endtask

	// ------------------------------------------------------------------
	// meas channel: random stall and check against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		meas_t exp_m;
		if (arst_n && meas_valid && !meas_stall) begin
			meas_checked++;
			if (scan_done)
				scans_seen++;
			if (pending_meas.size() == 0) begin
				note_fail($sformatf("unexpected item: angle=%0d status=%0d dist=%0d str=%0d done=%0d num=%0d",
					angle_deg, status_code, distance_mm, strength, scan_done, scan_index));
			end else begin
				exp_m = pending_meas.pop_front();
				if (angle_deg !== exp_m.angle || status_code !== exp_m.status
						|| distance_mm !== exp_m.dist_mm || strength !== exp_m.str
						|| scan_done !== exp_m.done || scan_index !== exp_m.num)
					note_fail($sformatf({"item error: exp angle=%0d status=%0d dist=%0d str=%0d",
						" done=%0d num=%0d, got angle=%0d status=%0d dist=%0d str=%0d",
						" done=%0d num=%0d"},
						exp_m.angle, exp_m.status, exp_m.dist_mm, exp_m.str, exp_m.done,
						exp_m.num, angle_deg, status_code, distance_mm, strength,
						scan_done, scan_index));
			end
		end
		if (stall_left > 0) begin
			meas_stall <= 1'b1;
			stall_left--;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			meas_stall <= 1'b1;
			stall_left = pick_gap() - 1;
		end else begin
			meas_stall <= 1'b0;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("range_scan_text_parser: mismatch");
			$finish;
		end
	end

	task automatic ref_state_init();
		clear_line();
		scans = 32'd0;
		bad_count = 0;
		bytes_sent = 0;
		lines_sent = 0;
		meas_checked = 0;
		scans_seen = 0;
		cycle_count = 0;
		stall_left = 0;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		ref_state_init();
		send_pct = 20;
		stall_pct = 20;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		for (int r = 0; r < DIR_ROWS; r++) begin
			line_buf.delete();
			add_text(dir_text[r]);
			use_typed = dir_ref[r].typed;
			typed_meas = dir_ref[r].m;
			send_line();
			use_typed = 1'b0;
		end

		// random lines; idling mode changes every 60 lines
		while (bytes_sent < TOTAL_BYTES) begin
			if (lines_sent % 60 == 0) begin
				case ($urandom_range(0, 3))
					0: begin send_pct = 0;  stall_pct = 0;  end
					1: begin send_pct = 25; stall_pct = 0;  end
					2: begin send_pct = 0;  stall_pct = 25; end
					default: begin send_pct = 25; stall_pct = 25; end
				endcase
			end
			build_line();
			send_line();
		end

		char_valid <= 1'b0;
		while (pending_meas.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_meas.size() != 0)
			note_fail($sformatf("%0d expected items never arrived", pending_meas.size()));

		$display("run covered %0d lines, %0d bytes, %0d items checked, %0d scan completions",
			lines_sent, bytes_sent, meas_checked, scans_seen);
		if (bad_count == 0)
			$display("range_scan_text_parser: match");
		else
			$display("range_scan_text_parser: mismatch");
		$finish;
	end

endmodule
